>>> rtl/assert_macros.svh
// Assertion macros shared by the route scan sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define ARSS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the block's own clk_i and rst_ni.
`define ARSS_ASSERT(lbl, prop, msg) \
  `ARSS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/arss_pkg.sv
// Types, codes and helper functions of the route scan sequencer.
package arss_pkg;

  localparam int ADC_W    = 2;
  localparam int CH_W     = 4;
  localparam int ROUTE_W  = ADC_W + CH_W;
  localparam int CFG_W    = 3;
  localparam int NUM_ADCS = 4;

  localparam logic [ADC_W-1:0] TOP_ADC  = ADC_W'(NUM_ADCS - 1);
  localparam logic [1:0]       LAST_GRP = 2'(NUM_ADCS - 1);

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_PLAN = 1'b1;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_SELECT = 2'd1,
    REQ_EMIT   = 2'd2
  } arss_req_e;

  typedef enum logic [1:0] {
    CHOICE_BOTH = 2'd0,
    CHOICE_LOW  = 2'd1,
    CHOICE_HIGH = 2'd2
  } arss_choice_e;

  typedef enum logic [1:0] {
    ORDER_INTERLEAVE = 2'd0,
    ORDER_PAIR       = 2'd1,
    ORDER_ADC_MAJOR  = 2'd2
  } arss_order_e;

  typedef enum logic [1:0] {
    CMP_EQ   = 2'd0,
    CMP_ADC  = 2'd1,
    CMP_KEEP = 2'd2
  } arss_cmp_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VAL,
    S_DUP_RD,
    S_DUP_CHK,
    S_ADD_END,
    S_PR_RD,
    S_PR_CHK,
    S_EM_PICK,
    S_EM_RD,
    S_EM_CHK,
    S_EM_FLUSH,
    S_REJ
  } arss_state_e;

  typedef struct packed {
    logic [1:0]       scan_order;
    logic [CFG_W-1:0] adc_num;
  } arss_cfg_t;

  typedef struct packed {
    logic            valid;
    logic            kind;
    logic            ok;
    logic [ADC_W-1:0] adc;
    logic [CH_W-1:0]  ch;
    logic            last;
  } arss_res_t;

  // ADC lies below the present count and inside the selected array.
  function automatic logic adc_chosen(logic [ADC_W-1:0] adc, arss_choice_e mode,
                                      logic [CFG_W-1:0] cnt);
    logic sel;
    sel = 1'b0;
    unique case (mode)
      CHOICE_BOTH: sel = 1'b1;
      CHOICE_LOW:  sel = ~adc[ADC_W-1];
      CHOICE_HIGH: sel = adc[ADC_W-1];
      default:     sel = 1'b0;
    endcase
    return sel && (CFG_W'(adc) < cnt);
  endfunction

  // ADCs visited by scan group grp under the given order.
  function automatic logic [NUM_ADCS-1:0] group_mask(logic [1:0] order, logic [1:0] grp,
                                                     logic [CFG_W-1:0] cnt);
    logic [NUM_ADCS-1:0] present;
    logic [NUM_ADCS-1:0] mask;
    for (int k = 0; k < NUM_ADCS; k++) begin
      present[k] = (CFG_W'(k) < cnt);
    end
    mask = '0;
    unique case (order)
      ORDER_ADC_MAJOR: mask = (NUM_ADCS'(1) << grp) & present;
      ORDER_PAIR: begin
        if (grp == 2'd0) begin
          mask = 4'b0011;
        end else if (grp == 2'd1) begin
          mask = 4'b1100;
        end
      end
      default: begin
        if (grp == 2'd0) begin
          mask = present;
        end
      end
    endcase
    return mask;
  endfunction

endpackage

>>> rtl/adc_route_scan_sequencer_unit.sv
// Top level of the ADC route table and scan-plan sequencer.
//
// One transaction is taken when start is high and busy is low; busy stays high
// until the block has worked it off. Every result shows on the result ports for
// exactly one cycle with result_valid_o high, through one output register after the sequencer
// produces it; the receiver cannot stall, so it must take each result as it
// comes. The last result of a transaction carries last_o and shows in the
// cycle busy drops, so a new start may be given right then. Each step of a
// transaction goes through one shared compare unit that reads the route memory
// through one registered read port, one entry examined at a time. An add
// searches the staged list for a duplicate, a select prunes the table in
// place, and an emit walks the table once with a cursor per ADC, visiting
// each ADC slot in each round. Commit flips the staged and committed halves
// of the memory, so it costs no copy. The route memory needs no clearing pass
// after reset. Write configuration only while busy is low and no result is
// still outstanding.
module adc_route_scan_sequencer_unit #(
  parameter int MAX_ROUTES   = 16,
  parameter int NUM_CHANNELS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type_i,
  input  logic [arss_pkg::ADC_W-1:0]    adc_index_i,
  input  logic [arss_pkg::CH_W-1:0]     channel_index_i,
  input  logic                          list_end_i,
  input  logic [1:0]                    array_choice_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [arss_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                          result_valid_o,
  output logic                          result_kind_o,
  output logic                          ok_o,
  output logic [arss_pkg::ADC_W-1:0]    plan_adc_o,
  output logic [arss_pkg::CH_W-1:0]     plan_channel_o,
  output logic                          last_o
);
  import arss_pkg::*;
  `include "assert_macros.svh"

  localparam logic CFG_SCAN_ORDER = 1'b0;
  localparam logic CFG_ADC_NUM    = 1'b1;

  arss_cfg_t cfg_q;
  arss_res_t res;
  logic      res_vld_q;
  arss_res_t res_pay_q;

  // Configuration registers: scan order resets to interleaved, all four ADCs present.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_order <= ORDER_INTERLEAVE;
      cfg_q.adc_num    <= CFG_W'(NUM_ADCS);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCAN_ORDER: cfg_q.scan_order <= cfg_data_i[1:0];
        CFG_ADC_NUM:    cfg_q.adc_num    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  arss_seq #(
    .MAX_ROUTES   (MAX_ROUTES),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .req_type_i      (req_type_i),
    .adc_index_i     (adc_index_i),
    .channel_index_i (channel_index_i),
    .list_end_i      (list_end_i),
    .array_choice_i  (array_choice_i),
    .cfg_i           (cfg_q),
    .busy_o          (busy),
    .res_o           (res)
  );

  // Output register: the strobe resets, the payload just follows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_pay_q <= res;
  end

  assign result_valid_o = res_vld_q;
  assign result_kind_o  = res_pay_q.kind;
  assign ok_o           = res_pay_q.ok;
  assign plan_adc_o     = res_pay_q.adc;
  assign plan_channel_o = res_pay_q.ch;
  assign last_o         = res_pay_q.last;

  `ARSS_ASSERT(a_res_in_txn, result_valid_o |-> $past(busy), "result outside a transaction")
  `ARSS_ASSERT(a_start_quiet, (start && !busy) |=> !result_valid_o, "result right after start")
  `ARSS_ASSERT(a_last_ends, result_valid_o |-> (last_o == !busy), "last flag and busy disagree")

endmodule

>>> rtl/arss_cmp.sv
// Shared route compare unit: equality, ADC match and keep test.
module arss_cmp #(
  parameter int NUM_CHANNELS = 16
) (
  input  arss_pkg::arss_cmp_e                 op_i,
  input  logic [arss_pkg::ROUTE_W-1:0]        entry_i,
  input  logic [arss_pkg::ROUTE_W-1:0]        key_i,
  input  arss_pkg::arss_choice_e              mode_i,
  input  logic [arss_pkg::CFG_W-1:0]          adc_num_i,
  output logic                                match_o
);
  import arss_pkg::*;

  localparam logic [CH_W:0] CH_LIM = (CH_W + 1)'(NUM_CHANNELS);

  logic [ADC_W-1:0] entry_adc;
  logic [CH_W-1:0]  entry_ch;

  assign entry_adc = entry_i[ROUTE_W-1:CH_W];
  assign entry_ch  = entry_i[CH_W-1:0];

  always_comb begin
    unique case (op_i)
      CMP_EQ:   match_o = (entry_i == key_i);
      CMP_ADC:  match_o = (entry_adc == key_i[ROUTE_W-1:CH_W]);
      CMP_KEEP: match_o = adc_chosen(entry_adc, mode_i, adc_num_i)
                          && ({1'b0, entry_ch} < CH_LIM);
      default:  match_o = 1'b0;
    endcase
  end

endmodule

>>> rtl/arss_seq.sv
// Sequencer with the staged and committed route memory.
`include "assert_macros.svh"

module arss_seq #(
  parameter int MAX_ROUTES   = 16,
  parameter int NUM_CHANNELS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    req_type_i,
  input  logic [arss_pkg::ADC_W-1:0]    adc_index_i,
  input  logic [arss_pkg::CH_W-1:0]     channel_index_i,
  input  logic                          list_end_i,
  input  logic [1:0]                    array_choice_i,
  input  arss_pkg::arss_cfg_t           cfg_i,
  output logic                          busy_o,
  output arss_pkg::arss_res_t           res_o
);
  import arss_pkg::*;

  localparam int IW    = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CW    = $clog2(MAX_ROUTES + 1);
  localparam int DEPTH = 2 ** (IW + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ROUTES);
  localparam logic [CW-1:0] ONE     = CW'(1);

  arss_state_e          state_q, state_d;
  logic [ROUTE_W-1:0]   route_q, route_d;
  logic                 end_q, end_d;
  logic [CW-1:0]        stg_cnt_q, stg_cnt_d;
  logic                 stg_bad_q, stg_bad_d;
  logic [CW-1:0]        total_q, total_d;
  logic                 tbl_bank_q, tbl_bank_d;
  arss_choice_e         mode_q, mode_d;
  logic [CW-1:0]        i_q, i_d;
  logic [CW-1:0]        kept_q, kept_d;
  logic [CW-1:0]        cur_q [NUM_ADCS];
  logic [CW-1:0]        cur_d [NUM_ADCS];
  logic [1:0]           grp_q, grp_d;
  logic [ADC_W-1:0]     a_q, a_d;
  logic                 hit_q, hit_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [ROUTE_W-1:0]   pend_route_q, pend_route_d;

  logic [ROUTE_W-1:0]   route_mem_q [DEPTH];
  logic [ROUTE_W-1:0]   rdata_q;
  logic                 rd_bank;
  logic [IW-1:0]        rd_idx;
  logic                 mem_we;
  logic [IW:0]          mem_wa;
  logic [ROUTE_W-1:0]   mem_wd;

  arss_cmp_e            cmp_op;
  logic [ROUTE_W-1:0]   cmp_entry;
  logic [ROUTE_W-1:0]   cmp_key;
  logic                 cmp_match;

  logic [NUM_ADCS-1:0]  mask;
  logic [CW-1:0]        cur_a;
  logic [CW-1:0]        cur_nxt;
  logic                 adv;
  logic                 commit;

  arss_cmp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_cmp (
    .op_i        (cmp_op),
    .entry_i     (cmp_entry),
    .key_i       (cmp_key),
    .mode_i      (mode_q),
    .adc_num_i   (cfg_i.adc_num),
    .match_o     (cmp_match)
  );

  assign mask    = group_mask(cfg_i.scan_order, grp_q, cfg_i.adc_num);
  assign cur_a   = cur_q[a_q];
  assign cur_nxt = cur_a + ONE;
  assign commit  = !stg_bad_q && (stg_cnt_q != '0);
  assign busy_o  = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    route_d      = route_q;
    end_d        = end_q;
    stg_cnt_d    = stg_cnt_q;
    stg_bad_d    = stg_bad_q;
    total_d      = total_q;
    tbl_bank_d   = tbl_bank_q;
    mode_d       = mode_q;
    i_d          = i_q;
    kept_d       = kept_q;
    cur_d        = cur_q;
    grp_d        = grp_q;
    a_d          = a_q;
    hit_d        = hit_q;
    pend_vld_d   = pend_vld_q;
    pend_route_d = pend_route_q;
    res_o        = '0;
    rd_bank      = tbl_bank_q;
    rd_idx       = i_q[IW-1:0];
    mem_we       = 1'b0;
    mem_wa       = {~tbl_bank_q, stg_cnt_q[IW-1:0]};
    mem_wd       = route_q;
    cmp_op       = CMP_EQ;
    cmp_entry    = rdata_q;
    cmp_key      = route_q;
    adv          = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          route_d = {adc_index_i, channel_index_i};
          end_d   = list_end_i;
          unique case (arss_req_e'(req_type_i))
            REQ_ADD: state_d = stg_bad_q ? S_ADD_END : S_VAL;
            REQ_SELECT: begin
              if (array_choice_i == CHOICE_BOTH || array_choice_i == CHOICE_LOW
                  || array_choice_i == CHOICE_HIGH) begin
                mode_d  = arss_choice_e'(array_choice_i);
                i_d     = '0;
                kept_d  = '0;
                state_d = S_PR_RD;
              end else begin
                state_d = S_REJ;
              end
            end
            REQ_EMIT: begin
              cur_d      = '{default: '0};
              grp_d      = '0;
              a_d        = '0;
              hit_d      = 1'b0;
              pend_vld_d = 1'b0;
              state_d    = S_EM_PICK;
            end
            default: state_d = S_REJ;
          endcase
        end
      end

      S_VAL: begin
        cmp_op    = CMP_KEEP;
        cmp_entry = route_q;
        if (!cmp_match) begin
          stg_bad_d = 1'b1;
          state_d   = S_ADD_END;
        end else begin
          i_d     = '0;
          state_d = S_DUP_RD;
        end
      end

      S_DUP_RD: begin
        rd_bank = ~tbl_bank_q;
        if (i_q == stg_cnt_q) begin
          // no duplicate: append, or spoil the list when full
          if (stg_cnt_q == MAX_CNT) begin
            stg_bad_d = 1'b1;
          end else begin
            mem_we    = 1'b1;
            stg_cnt_d = stg_cnt_q + ONE;
          end
          state_d = S_ADD_END;
        end else begin
          state_d = S_DUP_CHK;
        end
      end

      S_DUP_CHK: begin
        cmp_op = CMP_EQ;
        if (cmp_match) begin
          state_d = S_ADD_END;
        end else begin
          i_d     = i_q + ONE;
          state_d = S_DUP_RD;
        end
      end

      S_ADD_END: begin
        res_o.valid = 1'b1;
        res_o.kind  = KIND_ACK;
        res_o.last  = 1'b1;
        if (end_q) begin
          res_o.ok = commit;
          if (commit) begin
            tbl_bank_d = ~tbl_bank_q;
            total_d    = stg_cnt_q;
          end
          stg_cnt_d = '0;
          stg_bad_d = 1'b0;
        end else begin
          res_o.ok = !stg_bad_q;
        end
        state_d = S_IDLE;
      end

      S_PR_RD: begin
        if (i_q == total_q) begin
          total_d     = kept_q;
          res_o.valid = 1'b1;
          res_o.kind  = KIND_ACK;
          res_o.ok    = 1'b1;
          res_o.last  = 1'b1;
          state_d     = S_IDLE;
        end else begin
          state_d = S_PR_CHK;
        end
      end

      S_PR_CHK: begin
        cmp_op = CMP_KEEP;
        if (cmp_match) begin
          mem_we = 1'b1;
          mem_wa = {tbl_bank_q, kept_q[IW-1:0]};
          mem_wd = rdata_q;
          kept_d = kept_q + ONE;
        end
        i_d     = i_q + ONE;
        state_d = S_PR_RD;
      end

      S_EM_PICK: begin
        if (mask[a_q] && (cur_a < total_q)) begin
          state_d = S_EM_RD;
        end else begin
          adv = 1'b1;
        end
      end

      S_EM_RD: begin
        rd_idx  = cur_a[IW-1:0];
        state_d = S_EM_CHK;
      end

      S_EM_CHK: begin
        cmp_op     = CMP_ADC;
        cmp_key    = {a_q, CH_W'(0)};
        cur_d[a_q] = cur_nxt;
        if (cmp_match) begin
          // hold the new entry; release the previous one as not last
          if (pend_vld_q) begin
            res_o.valid = 1'b1;
            res_o.kind  = KIND_PLAN;
            res_o.ok    = 1'b1;
            res_o.adc   = pend_route_q[ROUTE_W-1:CH_W];
            res_o.ch    = pend_route_q[CH_W-1:0];
          end
          pend_vld_d   = 1'b1;
          pend_route_d = rdata_q;
          hit_d        = 1'b1;
          state_d      = S_EM_PICK;
          adv          = 1'b1;
        end else if (cur_nxt < total_q) begin
          state_d = S_EM_RD;
        end else begin
          state_d = S_EM_PICK;
          adv     = 1'b1;
        end
      end

      S_EM_FLUSH: begin
        res_o.valid = 1'b1;
        res_o.last  = 1'b1;
        if (pend_vld_q) begin
          res_o.kind = KIND_PLAN;
          res_o.ok   = 1'b1;
          res_o.adc  = pend_route_q[ROUTE_W-1:CH_W];
          res_o.ch   = pend_route_q[CH_W-1:0];
        end else begin
          res_o.kind = KIND_ACK;
        end
        state_d = S_IDLE;
      end

      S_REJ: begin
        res_o.valid = 1'b1;
        res_o.kind  = KIND_ACK;
        res_o.last  = 1'b1;
        state_d     = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    // step to the next ADC; close the round, and the group if the round found nothing
    if (adv) begin
      if (a_q != TOP_ADC) begin
        a_d = a_q + ADC_W'(1);
      end else begin
        a_d = '0;
        if (!hit_d) begin
          if (grp_q == LAST_GRP) begin
            state_d = S_EM_FLUSH;
          end else begin
            grp_d = grp_q + 2'd1;
          end
        end
        hit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      stg_cnt_q  <= '0;
      stg_bad_q  <= 1'b0;
      total_q    <= '0;
      tbl_bank_q <= 1'b0;
      mode_q     <= CHOICE_BOTH;
      i_q        <= '0;
      kept_q     <= '0;
      cur_q      <= '{default: '0};
      grp_q      <= '0;
      a_q        <= '0;
      hit_q      <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      stg_cnt_q  <= stg_cnt_d;
      stg_bad_q  <= stg_bad_d;
      total_q    <= total_d;
      tbl_bank_q <= tbl_bank_d;
      mode_q     <= mode_d;
      i_q        <= i_d;
      kept_q     <= kept_d;
      cur_q      <= cur_d;
      grp_q      <= grp_d;
      a_q        <= a_d;
      hit_q      <= hit_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    route_q      <= route_d;
    end_q        <= end_d;
    pend_route_q <= pend_route_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      route_mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= route_mem_q[{rd_bank, rd_idx}];
  end

  `ARSS_ASSERT(a_cnt_bound, (stg_cnt_q <= MAX_CNT) && (total_q <= MAX_CNT), "route count overflow")
  `ARSS_ASSERT(a_prune_behind, (state_q == S_PR_CHK) |-> (kept_q <= i_q), "prune writes ahead of reads")
  `ARSS_ASSERT(a_cursor_bound, (state_q == S_EM_RD) |-> (cur_a < total_q), "emit cursor past table end")

endmodule
